// ===== design/lspi_pkg.sv =====
// ---------------------------------------------------------------------------
// lspi_pkg
// Shared types, widths and codes of the looping sample player voice.
// ---------------------------------------------------------------------------
package lspi_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 14;
    localparam int PCM_W      = 16;
    localparam int LEN_W      = 15;
    localparam int CTRL_W     = 14;
    localparam int VOL_W      = 14;
    localparam int PHASE_W    = 27;
    localparam int CFG_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int SCALED_W   = PCM_W + VOL_W + 1;
    localparam int VOL_SHIFT  = 14;

    localparam logic [VOL_W-1:0]  VOL_UNITY   = 14'h3FFF;
    localparam logic [CTRL_W-1:0] PITCH_RESET = 14'h1000;
    localparam logic [LEN_W-1:0]  LEN_RESET   = 15'd2;
    localparam logic [LEN_W-1:0]  LEN_MIN     = 15'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_NOTE_ON = 2'd1,
        CMD_FRAME   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_LENGTH    = 3'd0,
        REG_LOOP_EN   = 3'd1,
        REG_LOOP_BASE = 3'd2,
        REG_PITCH     = 3'd3,
        REG_VOL_LEFT  = 3'd4,
        REG_VOL_RIGHT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]  sample_length;
        logic              loop_enable;
        logic [CTRL_W-1:0] loop_origin;
        logic [CTRL_W-1:0] pitch_step;
        logic [VOL_W-1:0]  volume_left;
        logic [VOL_W-1:0]  volume_right;
    } t_cfg;

    // Divide a scaled product by 16383, truncating toward zero. The estimate
    // (m + m/2^14) / 2^14 is never high and at most one low, so one
    // remainder check finishes the quotient.
    function automatic logic signed [PCM_W-1:0] lspi_div_unity(
        input logic signed [SCALED_W-1:0] p
    );
        logic [SCALED_W-1:0] mag;
        logic [SCALED_W-1:0] q;
        logic [SCALED_W:0]   r;
        mag = p[SCALED_W-1] ? SCALED_W'(-p) : SCALED_W'(p);
        q   = (mag + (mag >> VOL_SHIFT)) >> VOL_SHIFT;
        r   = {1'b0, mag} - {1'b0, q << VOL_SHIFT} + {1'b0, q};
        if (r >= (SCALED_W + 1)'(VOL_UNITY)) begin
            q = q + 1'b1;
        end
        return p[SCALED_W-1] ? PCM_W'(-q) : PCM_W'(q);
    endfunction

endpackage

// ===== design/lspi_cmd_if.sv =====
// ---------------------------------------------------------------------------
// lspi_cmd_if
// Command channel: sample writes, note-on and frame requests.
// ---------------------------------------------------------------------------
interface lspi_cmd_if;
    import lspi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [ADDR_W-1:0]       word_address;
    logic signed [PCM_W-1:0] word_value;

    modport source (output valid, output command, output word_address,
                    output word_value, input ready);
    modport sink   (input valid, input command, input word_address,
                    input word_value, output ready);
endinterface

// ===== design/lspi_frame_if.sv =====
// ---------------------------------------------------------------------------
// lspi_frame_if
// Frame channel: one stereo output word per frame request.
// ---------------------------------------------------------------------------
interface lspi_frame_if;
    import lspi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PCM_W-1:0] left_sample;
    logic signed [PCM_W-1:0] right_sample;
    logic                    finished;

    modport source (output valid, output left_sample, output right_sample,
                    output finished, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input finished, output ready);
endinterface

// ===== design/lspi_ram.sv =====
// ---------------------------------------------------------------------------
// lspi_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module lspi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/lspi_regs.sv =====
// ---------------------------------------------------------------------------
// lspi_regs
// APB register file holding the voice configuration.
// ---------------------------------------------------------------------------
module lspi_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lspi_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lspi_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lspi_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output lspi_pkg::t_cfg                     o_cfg
);
    import lspi_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[CFG_ADDR_W-1:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                REG_LENGTH:    n_cfg.sample_length = pwdata[LEN_W-1:0];
                REG_LOOP_EN:   n_cfg.loop_enable   = pwdata[0];
                REG_LOOP_BASE: n_cfg.loop_origin   = pwdata[CTRL_W-1:0];
                REG_PITCH:     n_cfg.pitch_step    = pwdata[CTRL_W-1:0];
                REG_VOL_LEFT:  n_cfg.volume_left   = pwdata[VOL_W-1:0];
                REG_VOL_RIGHT: n_cfg.volume_right  = pwdata[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_LENGTH:    prdata = APB_DATA_W'(r_cfg.sample_length);
            REG_LOOP_EN:   prdata = APB_DATA_W'(r_cfg.loop_enable);
            REG_LOOP_BASE: prdata = APB_DATA_W'(r_cfg.loop_origin);
            REG_PITCH:     prdata = APB_DATA_W'(r_cfg.pitch_step);
            REG_VOL_LEFT:  prdata = APB_DATA_W'(r_cfg.volume_left);
            REG_VOL_RIGHT: prdata = APB_DATA_W'(r_cfg.volume_right);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_length <= LEN_RESET;
            r_cfg.loop_enable   <= 1'b0;
            r_cfg.loop_origin   <= '0;
            r_cfg.pitch_step    <= PITCH_RESET;
            r_cfg.volume_left   <= VOL_UNITY;
            r_cfg.volume_right  <= VOL_UNITY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== design/lspi_rem.sv =====
// ---------------------------------------------------------------------------
// lspi_rem
// Restoring remainder unit, one dividend bit per cycle, used for loop wrap.
// ---------------------------------------------------------------------------
module lspi_rem #(
    parameter int DW = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_dividend,
    input  logic [lspi_pkg::LEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [lspi_pkg::LEN_W-1:0]  o_rem
);
    import lspi_pkg::*;

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            n_busy;
    logic            r_done;
    logic            n_done;
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic [DW-1:0]   r_dsh;
    logic [DW-1:0]   n_dsh;
    logic [LEN_W-1:0] r_div;
    logic [LEN_W-1:0] n_div;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] n_rem;
    logic [LEN_W:0]   w_trial;

    // The remainder stays below the divisor, so the trial fits one more bit.
    assign w_trial = {r_rem, r_dsh[DW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dsh  = r_dsh;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(DW);
            n_dsh  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dsh = r_dsh << 1;
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = LEN_W'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = w_trial[LEN_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dsh <= n_dsh;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== design/looping_sample_player_interp.sv =====
// ---------------------------------------------------------------------------
// looping_sample_player_interp
// One voice of a looping sample player with linear interpolation.
// ---------------------------------------------------------------------------
// Usage: words on i_cmd write PCM samples into the sample memory, start a
// note (phase and done flag cleared) or request one stereo frame. Only a
// frame request produces a word on o_frame. Configuration sits behind the
// APB port; the user must write it only while the voice is idle, as the
// block itself does not enforce this. A write or note-on leaves the voice
// idle. For a frame the sample memory has one read port, so the current
// word and its successor are read on consecutive cycles, followed by the
// interpolation multiply, the rounding add, the volume multiplies and the
// divide-by-16383 correction, after which the frame word is registered.
// When the phase has run past the end of a looping sample, a remainder
// unit working one bit per cycle wraps it first. A frame from a finished
// voice goes straight to a state that registers a silent word. No new command is taken until the voice is idle again.
// The output word sits in a register; the voice keeps taking commands while
// it waits, and a frame that finds the register still full holds its last
// step until the receiver takes the old word.
// Reset clears the phase, the done flag and the output valid bit; the sample
// memory is not cleared and must be written before it is played.
// ---------------------------------------------------------------------------
module looping_sample_player_interp #(
    parameter int SAMPLE_DEPTH  = 16384,
    parameter int FRACTION_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lspi_cmd_if.sink                         i_cmd,
    lspi_frame_if.source                     o_frame,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lspi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lspi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lspi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import lspi_pkg::*;

    localparam int AW  = $clog2(SAMPLE_DEPTH);
    localparam int IW  = PHASE_W - FRACTION_BITS;
    localparam int CW0 = (IW > LEN_W) ? IW : LEN_W;
    localparam int CW  = (CW0 > AW) ? CW0 : AW;
    localparam int PW  = FRACTION_BITS + PCM_W + 2;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV    = 9'b000000010,
        S_RD0    = 9'b000000100,
        S_RD1    = 9'b000001000,
        S_INTERP = 9'b000010000,
        S_VALUE  = 9'b000100000,
        S_SCALE  = 9'b001000000,
        S_FIN    = 9'b010000000,
        S_ZERO   = 9'b100000000
    } t_state;

    t_cfg w_cfg;

    t_state                      r_state;
    t_state                      n_state;
    logic [PHASE_W-1:0]          r_phase;
    logic [PHASE_W-1:0]          n_phase;
    logic                        r_done;
    logic                        n_done;
    logic signed [PCM_W-1:0]     r_s;
    logic signed [PCM_W-1:0]     n_s;
    logic signed [PW-1:0]        r_prod;
    logic signed [PW-1:0]        n_prod;
    logic signed [PCM_W-1:0]     r_value;
    logic signed [PCM_W-1:0]     n_value;
    logic signed [SCALED_W-1:0]  r_pl;
    logic signed [SCALED_W-1:0]  n_pl;
    logic signed [SCALED_W-1:0]  r_pr;
    logic signed [SCALED_W-1:0]  n_pr;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic signed [PCM_W-1:0]     r_out_left;
    logic signed [PCM_W-1:0]     n_out_left;
    logic signed [PCM_W-1:0]     r_out_right;
    logic signed [PCM_W-1:0]     n_out_right;
    logic                        r_out_finished;
    logic                        n_out_finished;

    logic [LEN_W-1:0]            w_len;
    logic                        w_looping;
    logic [LEN_W-1:0]            w_span_len;
    logic [CW-1:0]               w_idx_c;
    logic [CW-1:0]               w_len_c;
    logic [CW-1:0]               w_succ_c;
    logic [CW-1:0]               w_wrap_c;
    logic [CW-1:0]               w_waddr_c;
    logic [FRACTION_BITS-1:0]    w_frac;
    logic                        w_past_end;
    logic                        w_out_free;
    logic                        w_accept;
    logic                        w_we;
    logic [AW-1:0]               w_raddr;
    logic [PCM_W-1:0]            w_rdata;
    logic signed [PCM_W:0]       w_diff;
    logic signed [FRACTION_BITS:0] w_frac_s;
    logic signed [PW-1:0]        w_num;
    logic signed [PW-1:0]        w_bias;
    logic signed [PW-1:0]        w_num_adj;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [LEN_W-1:0]            w_rem;

    lspi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lspi_ram #(
        .WIDTH (PCM_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr_c[AW-1:0]),
        .i_wdata (i_cmd.word_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lspi_rem #(
        .DW (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_idx_c - w_len_c),
        .i_divisor  (w_span_len),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Effective length, saturated into two words up to the memory depth.
    always_comb begin
        if (w_cfg.sample_length < LEN_MIN) begin
            w_len = LEN_MIN;
        end else if (32'(w_cfg.sample_length) > SAMPLE_DEPTH) begin
            w_len = LEN_W'(SAMPLE_DEPTH);
        end else begin
            w_len = w_cfg.sample_length;
        end
    end

    assign w_looping  = w_cfg.loop_enable && (LEN_W'(w_cfg.loop_origin) < w_len);
    assign w_span_len = w_len - (w_looping ? LEN_W'(w_cfg.loop_origin) : LEN_W'(0));
    assign w_idx_c    = CW'(r_phase[PHASE_W-1:FRACTION_BITS]);
    assign w_len_c    = CW'(w_len);
    assign w_frac     = r_phase[FRACTION_BITS-1:0];
    assign w_past_end = w_idx_c >= w_len_c;

    // Successor of the last word is the loop start, or the word itself.
    always_comb begin
        if (w_idx_c + CW'(1) < w_len_c) begin
            w_succ_c = w_idx_c + CW'(1);
        end else if (w_looping) begin
            w_succ_c = CW'(w_cfg.loop_origin);
        end else begin
            w_succ_c = w_idx_c;
        end
    end

    assign w_wrap_c   = CW'(w_cfg.loop_origin) + CW'(w_rem);
    assign w_waddr_c  = CW'(i_cmd.word_address);
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_we       = w_accept && (i_cmd.command == CMD_WRITE)
                        && (32'(i_cmd.word_address) < SAMPLE_DEPTH);
    assign w_raddr    = (r_state == S_RD1) ? w_succ_c[AW-1:0] : w_idx_c[AW-1:0];
    assign w_out_free = !r_out_valid || o_frame.ready;

    assign w_diff    = $signed({w_rdata[PCM_W-1], w_rdata}) - $signed({r_s[PCM_W-1], r_s});
    assign w_frac_s  = $signed({1'b0, w_frac});
    assign w_num     = (PW'(r_s) <<< FRACTION_BITS) + r_prod;
    // Adding 2^F - 1 to a negative sum makes the arithmetic shift truncate
    // toward zero.
    assign w_bias    = $signed({{(PW - FRACTION_BITS){1'b0}}, {FRACTION_BITS{w_num[PW-1]}}});
    assign w_num_adj = w_num + w_bias;

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_frame.valid        = r_out_valid;
    assign o_frame.left_sample  = r_out_left;
    assign o_frame.right_sample = r_out_right;
    assign o_frame.finished     = r_out_finished;

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_done         = r_done;
        n_s            = r_s;
        n_prod         = r_prod;
        n_value        = r_value;
        n_pl           = r_pl;
        n_pr           = r_pr;
        n_out_valid    = r_out_valid && !o_frame.ready;
        n_out_left     = r_out_left;
        n_out_right    = r_out_right;
        n_out_finished = r_out_finished;
        w_div_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.command)
                        CMD_WRITE: ;
                        CMD_NOTE_ON: begin
                            n_phase = '0;
                            n_done  = 1'b0;
                        end
                        CMD_FRAME: begin
                            if (r_done) begin
                                n_state = S_ZERO;
                            end else if (w_past_end && w_looping) begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end else if (w_past_end) begin
                                n_done  = 1'b1;
                                n_state = S_ZERO;
                            end else begin
                                // The current word is being read this cycle.
                                n_state = S_RD1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_phase = {w_wrap_c[IW-1:0], w_frac};
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                n_s     = $signed(w_rdata);
                n_state = S_INTERP;
            end
            S_INTERP: begin
                n_prod  = w_frac_s * w_diff;
                n_state = S_VALUE;
            end
            S_VALUE: begin
                n_value = PCM_W'(w_num_adj >>> FRACTION_BITS);
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_pl    = r_value * $signed({1'b0, w_cfg.volume_left});
                n_pr    = r_value * $signed({1'b0, w_cfg.volume_right});
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_left     = lspi_div_unity(r_pl);
                    n_out_right    = lspi_div_unity(r_pr);
                    n_out_finished = 1'b0;
                    n_phase        = r_phase + PHASE_W'(w_cfg.pitch_step);
                    n_state        = S_IDLE;
                end
            end
            S_ZERO: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_left     = '0;
                    n_out_right    = '0;
                    n_out_finished = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_s            <= n_s;
        r_prod         <= n_prod;
        r_value        <= n_value;
        r_pl           <= n_pl;
        r_pr           <= n_pr;
        r_out_left     <= n_out_left;
        r_out_right    <= n_out_right;
        r_out_finished <= n_out_finished;
    end

    // A finished word always carries silence.
    a_finished_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_finished) |-> (r_out_left == '0 && r_out_right == '0))
        else $error("finished word with nonzero samples");

    // After a loop wrap the phase lies inside the sample.
    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> !w_past_end)
        else $error("wrapped phase still past the end");

    // The remainder unit only reports while a wrap is pending.
    a_rem_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("remainder result outside a wrap");

    // Reaching the end of a one-shot sample leads straight to a silent word.
    a_done_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> (r_state == S_ZERO))
        else $error("done flag set without a silent frame");
endmodule
